// ===== rtl/rle_prefix_count_column_defines.svh =====
// Assertion macros for the verification files of the run-length column.
`ifndef RLE_PREFIX_COUNT_COLUMN_DEFINES_SVH
`define RLE_PREFIX_COUNT_COLUMN_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define RLEPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlepc assertion failed");

// Check a consequence in the cycle after its trigger.
`define RLEPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlepc assertion failed");

`endif

// ===== rtl/rlepc_pkg.sv =====
// Shared constants, codes and types of the run-length encoded column.
package rlepc_pkg;

  localparam int MAX_RUNS  = 1024;
  localparam int MAX_ROWS  = 1048576;
  localparam int VALUE_W   = 32;
  localparam int RUN_IDX_W = $clog2(MAX_RUNS);
  localparam int RUN_CNT_W = RUN_IDX_W + 1;
  localparam int ROW_W     = 20;
  localparam int ROW_CNT_W = ROW_W + 1;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_STEP   = 4'b0100,
    S_VAL    = 4'b1000
  } state_e;

endpackage

// ===== rtl/rle_prefix_count_column.sv =====
// Run-length encoded column: run table with cumulative run ends and row lookup.
//
// Usage: the input channel (in_valid_i / in_ready_o) takes one beat holding
// command_i, value_in_i and row_index_i. The output channel (out_valid_o /
// out_ready_i) returns exactly one result beat per input beat, in order, with
// status_o, value_out_o, row_total_o and run_total_o.
// Append, clear and a rejected read finish in the accept cycle; their result
// appears in the cycle after. A read of the row just after the last read row,
// when that row was not row 0, takes one probe of the run-end memory, then one
// value read. Any other read runs a binary search, one run-end memory probe
// per cycle through a single compare unit, at most log2(runs)+1 probes plus
// one value read. The single read port of each memory allows one probe at a
// time. in_ready_o is low while a read is in progress.
// The result register lets a new beat in while a result waits, as long as
// the receiver takes that result in the same cycle; a stalled receiver holds
// the result and keeps in_ready_o low until that result is taken.
// Reset empties the table and clears the read tracking; no clearing pass runs.
module rle_prefix_count_column
  import rlepc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [VALUE_W-1:0]   value_in_i,
  input  logic [ROW_W-1:0]     row_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [VALUE_W-1:0]   value_out_o,
  output logic [ROW_CNT_W-1:0] row_total_o,
  output logic [RUN_CNT_W-1:0] run_total_o
);

  state_e                 state_q, state_d;
  logic [RUN_CNT_W-1:0]   runs_q, runs_d;
  logic [ROW_CNT_W-1:0]   rows_q, rows_d;
  logic [VALUE_W-1:0]     last_val_q, last_val_d;
  logic [ROW_W-1:0]       prev_row_q, prev_row_d;
  logic [RUN_IDX_W-1:0]   prev_run_q, prev_run_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [RUN_CNT_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [RUN_IDX_W-1:0]   mid_q, mid_d;
  logic [RUN_IDX_W-1:0]   r_q, r_d;

  logic                   out_valid_q, out_valid_d;
  logic [STAT_W-1:0]      out_stat_q, out_stat_d;
  logic [VALUE_W-1:0]     out_val_q, out_val_d;
  logic [ROW_CNT_W-1:0]   out_rows_q, out_rows_d;
  logic [RUN_CNT_W-1:0]   out_runs_q, out_runs_d;

  logic [ROW_CNT_W-1:0]   end_mem [MAX_RUNS];
  logic [VALUE_W-1:0]     val_mem [MAX_RUNS];
  logic                   end_wr_en, val_wr_en, end_rd_en, val_rd_en;
  logic [RUN_IDX_W-1:0]   end_wr_addr, val_wr_addr, end_rd_addr, val_rd_addr;
  logic [ROW_CNT_W-1:0]   end_wr_data, end_rd_q;
  logic [VALUE_W-1:0]     val_rd_q;

  logic                   accept, out_free, is_repeat, seq_hit, probe_gt, step_on;
  logic [RUN_IDX_W-1:0]   last_idx;
  logic [RUN_CNT_W-1:0]   lo_n, hi_n, mid_inc, r_inc;
  logic [RUN_CNT_W:0]     mid_sum;
  logic [RUN_IDX_W-1:0]   search_r;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign last_idx  = RUN_IDX_W'(runs_q - RUN_CNT_W'(1));
  assign is_repeat = (runs_q != '0) && (last_val_q == value_in_i);
  assign seq_hit   = (prev_row_q != '0) && (row_index_i != '0) &&
                     ((row_index_i - ROW_W'(1)) == prev_row_q) &&
                     ({1'b0, prev_run_q} < runs_q);

  assign probe_gt = end_rd_q > {1'b0, row_q};
  assign mid_inc  = {1'b0, mid_q} + RUN_CNT_W'(1);
  assign lo_n     = probe_gt ? lo_q : mid_inc;
  assign hi_n     = probe_gt ? {1'b0, mid_q} : hi_q;
  assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign search_r = (lo_n >= runs_q) ? last_idx : lo_n[RUN_IDX_W-1:0];
  assign r_inc    = {1'b0, r_q} + RUN_CNT_W'(1);
  assign step_on  = ({1'b0, row_q} >= end_rd_q) && (r_inc < runs_q);

  always_comb begin
    state_d     = state_q;
    runs_d      = runs_q;
    rows_d      = rows_q;
    last_val_d  = last_val_q;
    prev_row_d  = prev_row_q;
    prev_run_d  = prev_run_q;
    row_d       = row_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    r_d         = r_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    out_rows_d  = out_rows_q;
    out_runs_d  = out_runs_q;
    end_wr_en   = 1'b0;
    val_wr_en   = 1'b0;
    end_rd_en   = 1'b0;
    val_rd_en   = 1'b0;
    end_wr_addr = runs_q[RUN_IDX_W-1:0];
    val_wr_addr = runs_q[RUN_IDX_W-1:0];
    end_wr_data = rows_q + ROW_CNT_W'(1);
    end_rd_addr = mid_q;
    val_rd_addr = r_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_stat_d  = STAT_OK;
          out_val_d   = '0;
          case (command_i)
            CMD_APPEND: begin
              if (is_repeat) begin
                if (rows_q >= ROW_CNT_W'(MAX_ROWS)) begin
                  out_stat_d = STAT_FULL;
                end else begin
                  end_wr_en   = 1'b1;
                  end_wr_addr = last_idx;
                  rows_d      = rows_q + ROW_CNT_W'(1);
                end
              end else if (runs_q >= RUN_CNT_W'(MAX_RUNS) ||
                           rows_q >= ROW_CNT_W'(MAX_ROWS)) begin
                out_stat_d = STAT_FULL;
              end else begin
                end_wr_en  = 1'b1;
                val_wr_en  = 1'b1;
                rows_d     = rows_q + ROW_CNT_W'(1);
                runs_d     = runs_q + RUN_CNT_W'(1);
                last_val_d = value_in_i;
              end
            end
            CMD_READ: begin
              if (runs_q == '0 || {1'b0, row_index_i} >= rows_q) begin
                out_stat_d = STAT_BAD;
              end else begin
                out_valid_d = 1'b0;
                row_d       = row_index_i;
                end_rd_en   = 1'b1;
                if (seq_hit) begin
                  end_rd_addr = prev_run_q;
                  r_d         = prev_run_q;
                  state_d     = S_STEP;
                end else begin
                  lo_d        = '0;
                  hi_d        = runs_q;
                  mid_d       = runs_q[RUN_IDX_W:1];
                  end_rd_addr = runs_q[RUN_IDX_W:1];
                  state_d     = S_SEARCH;
                end
              end
            end
            CMD_CLEAR: begin
              runs_d     = '0;
              rows_d     = '0;
              prev_row_d = '0;
              prev_run_d = '0;
            end
            default: begin
            end
          endcase
          out_rows_d = rows_d;
          out_runs_d = runs_d;
        end
      end
      S_SEARCH: begin
        if (lo_n < hi_n) begin
          lo_d        = lo_n;
          hi_d        = hi_n;
          mid_d       = mid_sum[RUN_IDX_W:1];
          end_rd_en   = 1'b1;
          end_rd_addr = mid_sum[RUN_IDX_W:1];
        end else begin
          r_d         = search_r;
          val_rd_en   = 1'b1;
          val_rd_addr = search_r;
          state_d     = S_VAL;
        end
      end
      S_STEP: begin
        r_d         = step_on ? r_inc[RUN_IDX_W-1:0] : r_q;
        val_rd_en   = 1'b1;
        val_rd_addr = step_on ? r_inc[RUN_IDX_W-1:0] : r_q;
        state_d     = S_VAL;
      end
      S_VAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = STAT_OK;
          out_val_d   = val_rd_q;
          out_rows_d  = rows_q;
          out_runs_d  = runs_q;
          prev_row_d  = row_q;
          prev_run_d  = r_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      runs_q      <= '0;
      rows_q      <= '0;
      prev_row_q  <= '0;
      prev_run_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      runs_q      <= runs_d;
      rows_q      <= rows_d;
      prev_row_q  <= prev_row_d;
      prev_run_q  <= prev_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_val_q <= last_val_d;
    row_q      <= row_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    r_q        <= r_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
    out_rows_q <= out_rows_d;
    out_runs_q <= out_runs_d;
  end

  always_ff @(posedge clk_i) begin
    if (end_wr_en) begin
      end_mem[end_wr_addr] <= end_wr_data;
    end
    if (end_rd_en) begin
      end_rd_q <= end_mem[end_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_wr_en) begin
      val_mem[val_wr_addr] <= value_in_i;
    end
    if (val_rd_en) begin
      val_rd_q <= val_mem[val_rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_stat_q;
  assign value_out_o = out_val_q;
  assign row_total_o = out_rows_q;
  assign run_total_o = out_runs_q;

endmodule

// ===== rtl/rlepc_checker.sv =====
// Port-level checks of the run-length column, bound to the top level.
`include "rle_prefix_count_column_defines.svh"

module rlepc_checker
  import rlepc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [STAT_W-1:0]    status_o,
  input logic [VALUE_W-1:0]   value_out_o,
  input logic [ROW_CNT_W-1:0] row_total_o,
  input logic [RUN_CNT_W-1:0] run_total_o
);

  `RLEPC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(value_out_o) && $stable(row_total_o) && $stable(run_total_o))
  `RLEPC_ASSERT_NOW(a_stat_code, out_valid_o, status_o == STAT_OK || status_o == STAT_FULL || status_o == STAT_BAD)
  `RLEPC_ASSERT_NOW(a_val_zero, out_valid_o && status_o != STAT_OK, value_out_o == '0)
  `RLEPC_ASSERT_NOW(a_runs_rows, out_valid_o, {10'd0, run_total_o} <= row_total_o)
  `RLEPC_ASSERT_NOW(a_runs_max, out_valid_o, run_total_o <= RUN_CNT_W'(MAX_RUNS))

endmodule

bind rle_prefix_count_column rlepc_checker u_rlepc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .value_out_o (value_out_o),
  .row_total_o (row_total_o),
  .run_total_o (run_total_o)
);
